[rtl/core/mdf_pkg.sv]
// ----------------------------------------------------------------------------
// mdf_pkg
// Types, constants and register indexes shared by the deframer modules.
// ----------------------------------------------------------------------------
package mdf_pkg;

  localparam int ID_BYTES = 8;
  localparam int HDR_SIZE = 10 + 2 * ID_BYTES;
  localparam int HDR_AFTER_SIG = HDR_SIZE - 2;

  localparam int IDX_W = 5;
  localparam logic [IDX_W-1:0] IDX_LEN_LAST = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_SEQ_END = IDX_W'(6);
  localparam logic [IDX_W-1:0] IDX_CMD = IDX_W'(6);
  localparam logic [IDX_W-1:0] IDX_META = IDX_W'(7 + ID_BYTES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HDR_AFTER_SIG - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_LEN_ERR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [15:0]  seq;
    logic [7:0]   cmd;
    logic [63:0]  site;
    logic [7:0]   meta;
    logic [63:0]  meta_site;
    logic [15:0]  plen;
    logic [7:0]   pbyte;
    logic         last;
  } rec_t;

endpackage

[rtl/core/mdf_front.sv]
// ----------------------------------------------------------------------------
// mdf_front
// Signature hunt, header capture, length check and payload count; emits one
// result record per word that causes a result.
// ----------------------------------------------------------------------------
module mdf_front import mdf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_take,
  input  logic [7:0]           byte_in,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]          cfg_wdata,
  output logic                 rec_valid,
  output rec_t                 rec
);

  phase_t           phase_r, phase_nxt;
  logic             prev_match_r, prev_match_nxt;
  logic [IDX_W-1:0] hdr_idx_r, hdr_idx_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [63:0]      site_r, site_nxt;
  logic [7:0]       meta_r, meta_nxt;
  logic [63:0]      meta_site_r, meta_site_nxt;
  logic [15:0]      left_r, left_nxt;
  logic [7:0]       sig_first_r, sig_second_r;
  logic [15:0]      max_len_r;

  logic        sig_hit;
  logic        len_bad;
  logic        hdr_done;
  logic [15:0] plen;
  logic        pay_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_first_r  <= '0;
      sig_second_r <= '0;
      max_len_r    <= 16'hffff;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SIG_FIRST:  sig_first_r  <= cfg_wdata[7:0];
        REG_SIG_SECOND: sig_second_r <= cfg_wdata[7:0];
        REG_MAX_LEN:    max_len_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    len_nxt  = {len_r[23:0], byte_in};
    sig_hit  = prev_match_r && (byte_in == sig_second_r);
    len_bad  = (hdr_idx_r == IDX_LEN_LAST) &&
               ((len_nxt < 32'(HDR_SIZE)) || (len_nxt > {16'd0, max_len_r}));
    hdr_done = (hdr_idx_r == IDX_LAST);
    plen     = 16'(len_r - 32'(HDR_SIZE));
    pay_end  = (left_r <= 16'd1);
  end

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_HUNT: begin
        if (sig_hit) phase_nxt = PH_HEADER;
      end
      PH_HEADER: begin
        if (len_bad) phase_nxt = PH_HUNT;
        else if (hdr_done) phase_nxt = (plen == 16'd0) ? PH_HUNT : PH_PAYLOAD;
      end
      default: begin
        if (pay_end) phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_comb begin
    prev_match_nxt = prev_match_r;
    hdr_idx_nxt    = hdr_idx_r;
    seq_nxt        = seq_r;
    cmd_nxt        = cmd_r;
    site_nxt       = site_r;
    meta_nxt       = meta_r;
    meta_site_nxt  = meta_site_r;
    left_nxt       = left_r;
    rec_valid      = 1'b0;
    rec            = '0;
    unique case (phase_r)
      PH_HUNT: begin
        if (sig_hit) begin
          prev_match_nxt = 1'b0;
          hdr_idx_nxt    = '0;
          seq_nxt        = '0;
          cmd_nxt        = '0;
          site_nxt       = '0;
          meta_nxt       = '0;
          meta_site_nxt  = '0;
        end else begin
          prev_match_nxt = (byte_in == sig_first_r);
        end
      end
      PH_HEADER: begin
        priority if (hdr_idx_r <= IDX_LEN_LAST) begin
        end else if (hdr_idx_r < IDX_SEQ_END) begin
          seq_nxt = {seq_r[7:0], byte_in};
        end else if (hdr_idx_r == IDX_CMD) begin
          cmd_nxt = byte_in;
        end else if (hdr_idx_r < IDX_META) begin
          site_nxt = {site_r[55:0], byte_in};
        end else if (hdr_idx_r == IDX_META) begin
          meta_nxt = byte_in;
        end else begin
          meta_site_nxt = {meta_site_r[55:0], byte_in};
        end
        hdr_idx_nxt = hdr_idx_r + IDX_W'(1);
        if (len_bad) begin
          rec_valid      = 1'b1;
          rec.kind       = KIND_LEN_ERR;
          rec.last       = 1'b1;
          prev_match_nxt = 1'b0;
          hdr_idx_nxt    = '0;
        end else if (hdr_done) begin
          rec_valid      = 1'b1;
          rec.kind       = KIND_HEADER;
          rec.seq        = seq_nxt;
          rec.cmd        = cmd_nxt;
          rec.site       = site_nxt;
          rec.meta       = meta_nxt;
          rec.meta_site  = meta_site_nxt;
          rec.plen       = plen;
          rec.last       = (plen == 16'd0);
          left_nxt       = plen;
          prev_match_nxt = 1'b0;
          hdr_idx_nxt    = '0;
        end
      end
      default: begin
        rec_valid = 1'b1;
        rec.kind  = KIND_PAYLOAD;
        rec.pbyte = byte_in;
        rec.last  = pay_end;
        if (pay_end) begin
          left_nxt       = '0;
          prev_match_nxt = 1'b0;
          hdr_idx_nxt    = '0;
        end else begin
          left_nxt = left_r - 16'd1;
        end
      end
    endcase
    if (!byte_take) rec_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      prev_match_r <= 1'b0;
      hdr_idx_r    <= '0;
      left_r       <= '0;
    end else if (byte_take) begin
      phase_r      <= phase_nxt;
      prev_match_r <= prev_match_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      left_r       <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      if (phase_r == PH_HEADER && hdr_idx_r <= IDX_LEN_LAST) len_r <= len_nxt;
      else if (phase_r == PH_HUNT) len_r <= '0;
      seq_r       <= seq_nxt;
      cmd_r       <= cmd_nxt;
      site_r      <= site_nxt;
      meta_r      <= meta_nxt;
      meta_site_r <= meta_site_nxt;
    end
  end

endmodule

[rtl/core/mdf_queue.sv]
// ----------------------------------------------------------------------------
// mdf_queue
// Short register queue of result records between the parser and the output.
// ----------------------------------------------------------------------------
module mdf_queue import mdf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  input  logic pop,
  output rec_t head,
  output logic full,
  output logic not_empty
);

  rec_t               q_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == Q_CNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + Q_CNT_W'(1);
    else if (!push && pop) cnt_nxt = cnt_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_rec;
  end

endmodule

[rtl/core/mdf_back.sv]
// ----------------------------------------------------------------------------
// mdf_back
// Output stage: drives the result channel from the queue head, clearing the
// fields that do not belong to the result kind.
// ----------------------------------------------------------------------------
module mdf_back import mdf_pkg::*; (
  input  logic        head_valid,
  input  rec_t        head,
  input  logic        out_stall,
  output logic        pop,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [15:0] out_seq_number,
  output logic [7:0]  out_command_code,
  output logic [63:0] out_site_id,
  output logic [6:0]  out_meta_command,
  output logic        out_origin_bit,
  output logic [63:0] out_meta_site_id,
  output logic [15:0] out_payload_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_of_frame
);

  logic is_hdr, is_pay;

  assign out_valid = head_valid;
  assign pop       = head_valid && !out_stall;
  assign is_hdr    = (head.kind == KIND_HEADER);
  assign is_pay    = (head.kind == KIND_PAYLOAD);

  always_comb begin
    out_kind           = head.kind;
    out_last_of_frame  = head.last;
    out_seq_number     = is_hdr ? head.seq : '0;
    out_command_code   = is_hdr ? head.cmd : '0;
    out_site_id        = is_hdr ? head.site : '0;
    out_meta_command   = is_hdr ? head.meta[6:0] : '0;
    out_origin_bit     = is_hdr ? head.meta[7] : 1'b0;
    out_meta_site_id   = is_hdr ? head.meta_site : '0;
    out_payload_length = is_hdr ? head.plen : '0;
    out_payload_byte   = is_pay ? head.pbyte : '0;
  end

endmodule

[rtl/core/message_stream_deframer_core.sv]
// ----------------------------------------------------------------------------
// message_stream_deframer_core
// Byte-serial deframer for signed, length-prefixed messages.
//
// Input channel: one stream word per accepted in_valid/!in_stall edge.
// Result channel: header, payload byte or length error results, accepted
//   on out_valid/!out_stall; out_last_of_frame marks the end of a frame.
// Config channel: cfg_valid/cfg_ready write of signature bytes and the
//   largest frame length; cfg_ready is always high.
// Throughput: one word per cycle while in_stall is low, set by the per-word parser step.
// A result is registered in the queue when its word is accepted and is shown
//   from the head; only payload, length-error and last header words give one.
// A two-entry queue parts parser and output; in_stall rises only when
//   the queue is full, so a stalled receiver stops the input after at
//   most two pending results.
// Reset: synchronous, active low; the parser hunts for the signature with
//   no partial match, the queue empties and control and config registers reset.
// ----------------------------------------------------------------------------
module message_stream_deframer_core import mdf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_kind,
  output logic [15:0]          out_seq_number,
  output logic [7:0]           out_command_code,
  output logic [63:0]          out_site_id,
  output logic [6:0]           out_meta_command,
  output logic                 out_origin_bit,
  output logic [63:0]          out_meta_site_id,
  output logic [15:0]          out_payload_length,
  output logic [7:0]           out_payload_byte,
  output logic                 out_last_of_frame,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic byte_take;
  logic rec_valid;
  rec_t rec;
  rec_t head;
  logic q_full, q_not_empty, pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign byte_take = in_valid && !q_full;

  mdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .byte_in   (in_byte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  mdf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_valid),
    .push_rec  (rec),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  mdf_back u_back (
    .head_valid         (q_not_empty),
    .head               (head),
    .out_stall          (out_stall),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_kind           (out_kind),
    .out_seq_number     (out_seq_number),
    .out_command_code   (out_command_code),
    .out_site_id        (out_site_id),
    .out_meta_command   (out_meta_command),
    .out_origin_bit     (out_origin_bit),
    .out_meta_site_id   (out_meta_site_id),
    .out_payload_length (out_payload_length),
    .out_payload_byte   (out_payload_byte),
    .out_last_of_frame  (out_last_of_frame)
  );

endmodule

[test/message_stream_deframer_checker.sv]
// ----------------------------------------------------------------------------
// message_stream_deframer_checker
// Watches the byte, result and register channels of the deframer, keeps
// its own model of signature hunt, header capture and payload count, and
// compares every accepted result word with the oldest predicted one.
// ----------------------------------------------------------------------------
module message_stream_deframer_checker import mdf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           out_kind,
  input  logic [15:0]          out_seq_number,
  input  logic [7:0]           out_command_code,
  input  logic [63:0]          out_site_id,
  input  logic [6:0]           out_meta_command,
  input  logic                 out_origin_bit,
  input  logic [63:0]          out_meta_site_id,
  input  logic [15:0]          out_payload_length,
  input  logic [7:0]           out_payload_byte,
  input  logic                 out_last_of_frame,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output int unsigned          mismatch_count,
  output int unsigned          results_pending
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] seq_number;
    logic [7:0]  command_code;
    logic [63:0] site_id;
    logic [6:0]  meta_command;
    logic        origin_bit;
    logic [63:0] meta_site_id;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
  } frame_result_t;

  frame_result_t expected_results[$];

  logic [7:0]  sig_first_q;
  logic [7:0]  sig_second_q;
  logic [15:0] max_len_q;
  phase_t      parse_phase;
  logic        sig_armed;
  int          hdr_pos;
  logic [31:0] total_len;
  logic [15:0] seq_acc;
  logic [7:0]  cmd_acc;
  logic [63:0] site_acc;
  logic [7:0]  meta_acc;
  logic [63:0] meta_site_acc;
  logic [15:0] bytes_left;

  function automatic string describe(frame_result_t r);
    return $sformatf({"kind=%0d seq=%h cmd=%h site=%h meta=%h origin=%b ",
                      "msite=%h plen=%0d pbyte=%h last=%b"},
                     r.kind, r.seq_number, r.command_code, r.site_id,
                     r.meta_command, r.origin_bit, r.meta_site_id,
                     r.payload_length, r.payload_byte, r.last_of_frame);
  endfunction

  task automatic restart_hunt();
    parse_phase = PH_HUNT;
    sig_armed = 1'b0;
    hdr_pos = 0;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    frame_result_t r;
    bit emit;
    r = '0;
    emit = 1'b0;
    case (parse_phase)
      PH_HUNT: begin
        if (sig_armed && b == sig_second_q) begin
          parse_phase = PH_HEADER;
          hdr_pos = 0;
          sig_armed = 1'b0;
          total_len = '0;
          seq_acc = '0;
          cmd_acc = '0;
          site_acc = '0;
          meta_acc = '0;
          meta_site_acc = '0;
        end else begin
          sig_armed = (b == sig_first_q);
        end
      end
      PH_HEADER: begin
        if (hdr_pos < 4) total_len = {total_len[23:0], b};
        else if (hdr_pos < 6) seq_acc = {seq_acc[7:0], b};
        else if (hdr_pos == 6) cmd_acc = b;
        else if (hdr_pos < 7 + ID_BYTES) site_acc = {site_acc[55:0], b};
        else if (hdr_pos == 7 + ID_BYTES) meta_acc = b;
        else meta_site_acc = {meta_site_acc[55:0], b};

        if (hdr_pos == 3 && (total_len < HDR_SIZE || total_len > max_len_q)) begin
          r.kind = KIND_LEN_ERR;
          r.last_of_frame = 1'b1;
          emit = 1'b1;
          restart_hunt();
        end else if (hdr_pos + 1 < HDR_AFTER_SIG) begin
          hdr_pos++;
        end else begin
          bytes_left = 16'(total_len - HDR_SIZE);
          r.kind = KIND_HEADER;
          r.seq_number = seq_acc;
          r.command_code = cmd_acc;
          r.site_id = site_acc;
          r.meta_command = meta_acc[6:0];
          r.origin_bit = meta_acc[7];
          r.meta_site_id = meta_site_acc;
          r.payload_length = bytes_left;
          emit = 1'b1;
          if (bytes_left == 16'd0) begin
            r.last_of_frame = 1'b1;
            restart_hunt();
          end else begin
            parse_phase = PH_PAYLOAD;
            hdr_pos = 0;
          end
        end
      end
      default: begin
        r.kind = KIND_PAYLOAD;
        r.payload_byte = b;
        emit = 1'b1;
        if (bytes_left <= 16'd1) begin
          bytes_left = '0;
          r.last_of_frame = 1'b1;
          restart_hunt();
        end else begin
          bytes_left = bytes_left - 16'd1;
        end
      end
    endcase
    if (emit) expected_results.push_back(r);
  endtask

  task automatic check_result();
    frame_result_t got;
    frame_result_t want;
    got.kind = kind_t'(out_kind);
    got.seq_number = out_seq_number;
    got.command_code = out_command_code;
    got.site_id = out_site_id;
    got.meta_command = out_meta_command;
    got.origin_bit = out_origin_bit;
    got.meta_site_id = out_meta_site_id;
    got.payload_length = out_payload_length;
    got.payload_byte = out_payload_byte;
    got.last_of_frame = out_last_of_frame;
    if (expected_results.size() == 0) begin
      if (mismatch_count < REPORT_LIMIT)
        $display("unexpected result word at %0t: %s", $time, describe(got));
      mismatch_count++;
    end else begin
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.seq_number !== want.seq_number ||
          got.command_code !== want.command_code || got.site_id !== want.site_id ||
          got.meta_command !== want.meta_command ||
          got.origin_bit !== want.origin_bit ||
          got.meta_site_id !== want.meta_site_id ||
          got.payload_length !== want.payload_length ||
          got.payload_byte !== want.payload_byte ||
          got.last_of_frame !== want.last_of_frame) begin
        if (mismatch_count < REPORT_LIMIT) begin
          $display("result mismatch at %0t", $time);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sig_first_q = '0;
      sig_second_q = '0;
      max_len_q = 16'hFFFF;
      restart_hunt();
      total_len = '0;
      seq_acc = '0;
      cmd_acc = '0;
      site_acc = '0;
      meta_acc = '0;
      meta_site_acc = '0;
      bytes_left = '0;
      mismatch_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) predict_byte(in_byte);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SIG_FIRST:  sig_first_q = cfg_data[7:0];
          REG_SIG_SECOND: sig_second_q = cfg_data[7:0];
          REG_MAX_LEN:    max_len_q = cfg_data;
          default: ;
        endcase
      end
    end
    results_pending = expected_results.size();
  end

endmodule

[test/message_stream_deframer_core_tb.sv]
// ----------------------------------------------------------------------------
// message_stream_deframer_core_tb
// Drives framed byte streams, noise and broken frames into the deframer
// under several signature and length settings, with bursty input and a
// stalling receiver; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module message_stream_deframer_core_tb import mdf_pkg::*;;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 20;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BYTES = 160;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_kind;
  logic [15:0]          out_seq_number;
  logic [7:0]           out_command_code;
  logic [63:0]          out_site_id;
  logic [6:0]           out_meta_command;
  logic                 out_origin_bit;
  logic [63:0]          out_meta_site_id;
  logic [15:0]          out_payload_length;
  logic [7:0]           out_payload_byte;
  logic                 out_last_of_frame;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  int unsigned          mismatch_count;
  int unsigned          results_pending;

  logic [7:0]           sig_first;
  logic [7:0]           sig_second;
  logic [15:0]          max_len;
  int                   burst_left;
  int                   bytes_sent;
  int unsigned          hold_req_count = 0;
  int unsigned          hold_done_count = 0;

  always #2 clk = ~clk;

  message_stream_deframer_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_seq_number     (out_seq_number),
    .out_command_code   (out_command_code),
    .out_site_id        (out_site_id),
    .out_meta_command   (out_meta_command),
    .out_origin_bit     (out_origin_bit),
    .out_meta_site_id   (out_meta_site_id),
    .out_payload_length (out_payload_length),
    .out_payload_byte   (out_payload_byte),
    .out_last_of_frame  (out_last_of_frame),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  message_stream_deframer_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_seq_number     (out_seq_number),
    .out_command_code   (out_command_code),
    .out_site_id        (out_site_id),
    .out_meta_command   (out_meta_command),
    .out_origin_bit     (out_origin_bit),
    .out_meta_site_id   (out_meta_site_id),
    .out_payload_length (out_payload_length),
    .out_payload_byte   (out_payload_byte),
    .out_last_of_frame  (out_last_of_frame),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatch_count     (mismatch_count),
    .results_pending    (results_pending)
  );

  task automatic push_byte(input logic [7:0] b, input bit counted);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid = 1'b1;
    in_byte = b;
    do @(posedge clk); while (in_stall);
    if (counted) bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] sf, input logic [7:0] ss,
                                input logic [15:0] ml, input bit poke_unused);
    wait_drained();
    write_reg(REG_SIG_FIRST, {8'($urandom), sf});
    write_reg(REG_SIG_SECOND, {8'($urandom), ss});
    write_reg(REG_MAX_LEN, ml);
    if (poke_unused) write_reg(REG_UNUSED, 16'($urandom));
    cfg_valid = 1'b0;
    sig_first = sf;
    sig_second = ss;
    max_len = ml;
  endtask

  task automatic random_settings();
    logic [7:0]  sf;
    logic [7:0]  ss;
    logic [15:0] ml;
    int unsigned r;
    sf = 8'($urandom);
    ss = ($urandom_range(0, 4) == 0) ? sf : 8'($urandom);
    r = $urandom_range(0, 9);
    if (r < 2) ml = 16'hFFFF;
    else if (r < 3) ml = 16'($urandom_range(0, HDR_SIZE - 1));
    else if (r < 4) ml = 16'(HDR_SIZE);
    else ml = 16'($urandom_range(HDR_SIZE + 1, 120));
    apply_settings(sf, ss, ml, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_frame(input logic [31:0] total, input int prefix, input int fill);
    bit accepted;
    accepted = (total >= HDR_SIZE) && (total <= max_len);
    repeat (prefix) push_byte(sig_first, 1'b1);
    push_byte(sig_first, 1'b1);
    push_byte(sig_second, 1'b1);
    for (int i = 3; i >= 0; i--) push_byte(total[8*i +: 8], 1'b1);
    if (accepted)
      repeat (total - 6) push_byte((fill < 0) ? 8'($urandom) : 8'(fill), 1'b1);
  endtask

  task automatic send_noise(input int n);
    repeat (n) push_byte(($urandom_range(0, 3) == 0) ? sig_first : 8'($urandom), 1'b0);
  endtask

  // stop mid-header; the next frame's bytes finish it
  task automatic send_broken();
    logic [31:0] total;
    push_byte(sig_first, 1'b1);
    push_byte(sig_second, 1'b1);
    if (max_len >= HDR_SIZE) begin
      total = $urandom_range(HDR_SIZE, (max_len < HDR_SIZE + 16) ? max_len : HDR_SIZE + 16);
      for (int i = 3; i >= 0; i--) push_byte(total[8*i +: 8], 1'b1);
      repeat ($urandom_range(0, HDR_AFTER_SIG - 5)) push_byte(8'($urandom), 1'b1);
    end else begin
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b1);
    end
  endtask

  function automatic logic [31:0] pick_total();
    int unsigned r;
    int unsigned hi;
    r = $urandom_range(0, 99);
    if (r < 4 && max_len >= HDR_SIZE) begin
      hi = (max_len < 300) ? max_len : 300;
      return $urandom_range(HDR_SIZE, hi);
    end
    if (r < 75 && max_len >= HDR_SIZE) begin
      hi = (max_len < HDR_SIZE + 24) ? max_len : HDR_SIZE + 24;
      return $urandom_range(HDR_SIZE, hi);
    end
    if (r < 86) return $urandom_range(0, HDR_SIZE - 1);
    if (r < 93 && max_len < 16'hFFFF) return 32'(max_len) + 1 + $urandom_range(0, 3);
    return 32'($urandom) | 32'h0001_0000;
  endfunction

  task automatic random_traffic(input int budget, input bit with_hold);
    int          stop_at;
    int unsigned pick;
    stop_at = bytes_sent + budget;
    if (with_hold) hold_req_count++;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 72)
        send_frame(pick_total(), ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0, -1);
      else if (pick < 84) send_noise($urandom_range(1, 8));
      else if (pick < 95) send_broken();
      else wait_drained();
    end
  endtask

  initial begin : receiver
    rx_mode_t mode;
    int       span;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_done_count != hold_req_count) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done_count++;
      end else begin
        mode = rx_mode_t'($urandom_range(0, 3));
        span = $urandom_range(4, 40);
        repeat (span) begin
          case (mode)
            RX_FREE:  out_stall = 1'b0;
            RX_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
            RX_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
            default:  out_stall = ~out_stall;
          endcase
          @(negedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int drain;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SIG_FIRST;
    cfg_data = '0;
    sig_first = '0;
    sig_second = '0;
    max_len = 16'hFFFF;
    burst_left = 0;
    bytes_sent = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: zero signature, widest length
    send_frame(HDR_SIZE, 0, 8'h00);
    send_frame(32'h0001_0000, 0, -1);
    send_frame(32'hFFFF_FFFF, 0, -1);

    apply_settings(8'hA5, 8'h5A, 16'(HDR_SIZE + 34), 1'b0);
    send_frame(HDR_SIZE - 1, 0, -1);
    send_frame(HDR_SIZE + 34, 0, 8'hFF);
    send_frame(HDR_SIZE + 35, 0, -1);
    send_frame(HDR_SIZE + 1, 0, 8'h00);
    send_frame(HDR_SIZE, 2, -1);
    push_byte(sig_first, 1'b0);
    push_byte(8'h00, 1'b0);
    send_frame(32'd0, 0, -1);

    apply_settings(8'hFF, 8'hFF, 16'(HDR_SIZE), 1'b0);
    send_frame(HDR_SIZE, 0, -1);
    send_frame(HDR_SIZE + 1, 0, -1);
    send_frame(HDR_SIZE, 1, -1);

    apply_settings(8'h00, 8'hFF, 16'h0000, 1'b1);
    send_frame(HDR_SIZE, 0, -1);

    apply_settings(8'h3C, 8'hC3, 16'hFFFF, 1'b0);
    send_frame(HDR_SIZE + 300, 0, -1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_settings();
      random_traffic(PHASE_BYTES, (p % 2) == 0);
    end

    in_valid = 1'b0;
    drain = 0;
    while (results_pending != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
